/* design/sass_pkg.sv */
// Shared types, constants and helper functions for the sorted adjacency set store.
package sass_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int ROW_W        = 64;
    localparam int VTX_W        = 6;
    localparam int NVTX_W       = 7;
    localparam int COUNT_W      = 13;
    localparam int ADDR_W       = 3;
    localparam int DATA_W       = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [NVTX_W-1:0]  NVTX_RST  = NVTX_W'(MAX_VERTICES);
    localparam logic [NVTX_W-1:0]  NVTX_CLAMP = NVTX_W'(MAX_VERTICES);

    // operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LIST   = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // register index of num_vertices
    localparam logic REG_NUM_VERTICES = 1'b0;

    typedef struct packed {
        logic capture;
        logic evaluate;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic slot_free;
        logic done;
    } t_dp_sts;

    // clamp the configured vertex count to the row count
    function automatic logic [NVTX_W-1:0] vertex_limit(input logic [NVTX_W-1:0] n);
        return (n > NVTX_CLAMP) ? NVTX_CLAMP : n;
    endfunction

    // index of the single set bit of a one-hot row
    function automatic logic [VTX_W-1:0] onehot_index(input logic [ROW_W-1:0] v);
        logic [VTX_W-1:0] idx;
        idx = '0;
        for (int b = 0; b < VTX_W; b++) begin
            for (int i = 0; i < ROW_W; i++) begin
                if (i[b]) begin
                    idx[b] = idx[b] | v[i];
                end
            end
        end
        return idx;
    endfunction

endpackage

/* design/sass_ctrl.sv */
// Controller state machine: sequences capture, row lookup and result emission.
module sass_ctrl
    import sass_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stall <= 1'b1;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && !r_stall) begin
                        r_state <= S_LOOK;
                        r_stall <= 1'b1;
                    end else begin
                        r_stall <= 1'b0;
                    end
                end
                S_LOOK: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_sts.slot_free && i_sts.done) begin
                        r_state <= S_IDLE;
                        r_stall <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_stall <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd.capture  = (r_state == S_IDLE) && i_valid && !r_stall;
        o_cmd.evaluate = (r_state == S_LOOK);
        o_cmd.emit     = (r_state == S_OUT) && i_sts.slot_free;
    end

    assign o_stall = r_stall;

endmodule

/* design/sass_dpath.sv */
// Datapath: adjacency row memory, edge counter, neighbour scan and output register.
module sass_dpath
    import sass_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    input  logic                i_operation,
    input  logic [VTX_W-1:0]    i_source_vertex,
    input  logic [VTX_W-1:0]    i_target_vertex,
    input  logic [NVTX_W-1:0]   i_num_vertices,
    input  logic                i_stall,
    output logic                o_valid,
    output logic [VTX_W-1:0]    o_neighbor,
    output logic                o_last,
    output logic                o_added,
    output logic [COUNT_W-1:0]  o_edge_count,
    output logic [1:0]          o_status
);

    logic [ROW_W-1:0]        r_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] r_row_vld;
    logic [ROW_W-1:0]        r_mem_q;
    logic                    r_vld_q;

    logic                    r_op;
    logic [VTX_W-1:0]        r_src;
    logic [VTX_W-1:0]        r_dst;
    logic                    r_in_range;

    logic                    r_single;
    logic                    r_res_added;
    logic [1:0]              r_res_status;
    logic [ROW_W-1:0]        r_scan;
    logic [COUNT_W-1:0]      r_edge_total;

    logic                    r_o_valid;
    logic [VTX_W-1:0]        r_neighbor;
    logic                    r_last;
    logic                    r_added;
    logic [COUNT_W-1:0]      r_count;
    logic [1:0]              r_status;

    logic [NVTX_W-1:0]       lim;
    logic                    in_range;
    logic [ROW_W-1:0]        row;
    logic [ROW_W-1:0]        dst_bit;
    logic                    wr_en;
    logic [ROW_W-1:0]        low_bit;
    logic                    scan_last;

    assign lim      = vertex_limit(i_num_vertices);
    assign in_range = ({1'b0, i_source_vertex} < lim) &&
                      ((i_operation == OP_LIST) || ({1'b0, i_target_vertex} < lim));

    assign row       = r_vld_q ? r_mem_q : '0;
    assign dst_bit   = {{(ROW_W-1){1'b0}}, 1'b1} << r_dst;
    assign wr_en     = i_cmd.evaluate && (r_op == OP_INSERT) && r_in_range &&
                       ((row & dst_bit) == '0);
    assign low_bit   = r_scan & (~r_scan + {{(ROW_W-1){1'b0}}, 1'b1});
    assign scan_last = (r_scan == low_bit);

    // row memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_src] <= row | dst_bit;
        end
        if (i_cmd.capture) begin
            r_mem_q <= r_mem[i_source_vertex];
        end
    end

    // per-row valid bits stand in for clearing the memory at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld    <= '0;
            r_edge_total <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            if (wr_en) begin
                r_row_vld[r_src] <= 1'b1;
                if (r_edge_total != COUNT_MAX) begin
                    r_edge_total <= r_edge_total + COUNT_W'(1);
                end
            end
            if (i_cmd.emit) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= i_operation;
            r_src      <= i_source_vertex;
            r_dst      <= i_target_vertex;
            r_in_range <= in_range;
            r_vld_q    <= r_row_vld[i_source_vertex];
        end
        if (i_cmd.evaluate) begin
            r_scan <= row;
            priority if (!r_in_range) begin
                r_single     <= 1'b1;
                r_res_added  <= 1'b0;
                r_res_status <= ST_RANGE;
            end else if (r_op == OP_INSERT) begin
                r_single     <= 1'b1;
                r_res_added  <= wr_en;
                r_res_status <= ST_OK;
            end else if (row == '0) begin
                r_single     <= 1'b1;
                r_res_added  <= 1'b0;
                r_res_status <= ST_EMPTY;
            end else begin
                r_single     <= 1'b0;
                r_res_added  <= 1'b0;
                r_res_status <= ST_OK;
            end
        end
        if (i_cmd.emit) begin
            r_count <= r_edge_total;
            if (r_single) begin
                r_neighbor <= '0;
                r_last     <= 1'b1;
                r_added    <= r_res_added;
                r_status   <= r_res_status;
            end else begin
                r_neighbor <= onehot_index(low_bit);
                r_last     <= scan_last;
                r_added    <= 1'b0;
                r_status   <= ST_OK;
                r_scan     <= r_scan & ~low_bit;
            end
        end
    end

    always_comb begin
        o_sts.slot_free = !r_o_valid || !i_stall;
        o_sts.done      = r_single || scan_last;
    end

    assign o_valid      = r_o_valid;
    assign o_neighbor   = r_neighbor;
    assign o_last       = r_last;
    assign o_added      = r_added;
    assign o_edge_count = r_count;
    assign o_status     = r_status;

endmodule

/* design/sorted_adjacency_set_store.sv */
// Top level of the sorted adjacency set store: register port, controller and datapath.
//
//   channel  direction  handshake          payload
//   input    in         i_valid / o_stall  i_operation, i_source_vertex, i_target_vertex
//   result   out        o_valid / i_stall  o_neighbor, o_last, o_added, o_edge_count, o_status
//   config   in         psel/penable/...   paddr, pwdata, prdata (num_vertices at 0x0)
//
// An insert steps through capture, S_LOOK and S_OUT: the accepting edge reads the row,
// S_LOOK checks it and sets the new bit, S_OUT loads the result register and o_valid
// rises. A list of k neighbours gives one neighbour a cycle while i_stall is low, with
// one result for an empty or rejected list. One item is in work at a time.
// Reset clears every row through per-row valid bits; no clearing pass.
// A stalled result holds in the output register; the scan waits behind it.
module sorted_adjacency_set_store
    import sass_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input item channel
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_operation,
    input  logic [VTX_W-1:0]    i_source_vertex,
    input  logic [VTX_W-1:0]    i_target_vertex,
    // result channel
    output logic                o_valid,
    input  logic                i_stall,
    output logic [VTX_W-1:0]    o_neighbor,
    output logic                o_last,
    output logic                o_added,
    output logic [COUNT_W-1:0]  o_edge_count,
    output logic [1:0]          o_status,
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    logic [NVTX_W-1:0] r_num_vertices;
    logic              reg_hit;
    t_dp_cmd           cmd;
    t_dp_sts           sts;

    // word index sits above the byte offset; only index zero is populated
    assign reg_hit = (paddr[ADDR_W-1] == REG_NUM_VERTICES);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? {{(DATA_W-NVTX_W){1'b0}}, r_num_vertices} : '0;

    // take the vertex count on the access phase of a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_vertices <= NVTX_RST;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            r_num_vertices <= pwdata[NVTX_W-1:0];
        end
    end

    sass_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    sass_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_operation     (i_operation),
        .i_source_vertex (i_source_vertex),
        .i_target_vertex (i_target_vertex),
        .i_num_vertices  (r_num_vertices),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_neighbor      (o_neighbor),
        .o_last          (o_last),
        .o_added         (o_added),
        .o_edge_count    (o_edge_count),
        .o_status        (o_status)
    );

endmodule

/* design/sass_chk.sv */
// Port-level checker for the sorted adjacency set store, bound to the top level.
module sass_chk
    import sass_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic [VTX_W-1:0]    o_neighbor,
    input logic                o_last,
    input logic                o_added,
    input logic [COUNT_W-1:0]  o_edge_count,
    input logic [1:0]          o_status
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_neighbor) && $stable(o_last) &&
                               $stable(o_added) && $stable(o_status) &&
                               $stable(o_edge_count))
        else $error("stalled result changed");

    // an accepted item keeps the input stalled while it is in work
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after acceptance");

    // range errors and empty lists give a single result with no neighbour
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_RANGE || o_status == ST_EMPTY) |->
            o_last && (o_neighbor == '0) && !o_added)
        else $error("error or empty result malformed");

    // a new edge is reported only on an ok, final result with a non-zero count
    a_added: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_added |-> o_last && (o_status == ST_OK) && (o_edge_count != '0))
        else $error("added flag on a malformed result");

    // no result is shown right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind sorted_adjacency_set_store sass_chk u_sass_chk (.*);
